FILE: src/tkn_pkg.sv
// shared types and constants for the top-k nearest heap selection unit
package tkn_pkg;

    localparam int KEY_W   = 32;
    localparam int ID_W    = 64;
    localparam int KEEP_W  = 7;
    localparam int TDATA_W = 96;

    typedef enum logic {
        CMD_OFFER = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    // one heap slot, packed so that the id sits in the low bits
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/tkn_ram.sv
// generic single-write dual-read ram with registered read data
module tkn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                          rd_data_a,
    output logic [WIDTH-1:0]                          rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: src/top_k_nearest_heap_select_unit.sv
// top-k nearest selection: bounded max-heap in ram, shared compare sequencer
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    s_tdata {candidate_id, distance}, s_tuser command
//   m_        out  m_tvalid/m_tready    m_tdata {out_distance, out_id}, m_tlast last
//   cfg_      in   cfg_valid/cfg_ready  cfg_data keep_count
//
// offer: a rejected item is dropped straight from idle, else each heap level walked
//   takes one ram read, then one compare and write
// drain: per entry a pop (ram read, then write) plus a sift-down, then per result
//   beat a ram read and a beat held until m_tready; the heap is sorted in place in ram
// reset clears fill level and sets keep_count to 1; ram contents are not cleared
// s_tready stays low while an item is in work or results are pending
module top_k_nearest_heap_select_unit #(
    parameter int MAX_KEEP = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tkn_pkg::TDATA_W-1:0]   s_tdata,   // distance[31:0], candidate_id[95:32]
    input  logic                          s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tkn_pkg::TDATA_W-1:0]   m_tdata,   // out_id[63:0], out_distance[95:64]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tkn_pkg::KEEP_W-1:0]    cfg_data
);

    import tkn_pkg::*;

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int XW = AW + 2;
    localparam int EW = (CW > KEEP_W) ? CW : KEEP_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FIN,
        ST_PO_RD,
        ST_PO_WR,
        ST_EM_RD,
        ST_EM_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [KEEP_W-1:0]   keep_reg, keep_next;
    entry_t              mv_reg, mv_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       pop_reg, pop_next;
    logic [CW-1:0]       emit_reg, emit_next;
    logic                drain_reg, drain_next;
    entry_t              root_reg, root_next;

    entry_t              in_entry;
    entry_t              rd_a;
    entry_t              rd_b;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr_a;

    logic [EW-1:0]       keep_ext;
    logic [EW-1:0]       k_eff;
    logic                has_room;
    logic [XW-1:0]       left_idx;
    logic [XW-1:0]       right_idx;
    logic [XW-1:0]       lim_x;
    logic [AW-1:0]       parent_idx;
    logic                l_gt;
    logic signed [KEY_W-1:0] best_key;
    logic                r_gt;
    logic [CW-1:0]       last_pos;
    logic [CW-1:0]       pop_last;
    logic                sift_done;

    assign in_entry.key = s_tdata[KEY_W-1:0];
    assign in_entry.id  = s_tdata[KEY_W +: ID_W];

    // zero keep_count acts as 1, anything above the heap size saturates
    assign keep_ext = EW'(keep_reg);
    assign k_eff    = (keep_ext == '0) ? EW'(1) :
                      ((keep_ext > EW'(MAX_KEEP)) ? EW'(MAX_KEEP) : keep_ext);
    assign has_room = EW'(fill_reg) < k_eff;

    assign left_idx   = (XW'(pos_reg) << 1) + XW'(1);
    assign right_idx  = left_idx + XW'(1);
    assign lim_x      = XW'(lim_reg);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;

    // strict compares, left child wins a tie
    assign l_gt     = $signed(rd_a.key) > $signed(mv_reg.key);
    assign best_key = l_gt ? rd_a.key : mv_reg.key;
    assign r_gt     = (right_idx < lim_x) && ($signed(rd_b.key) > $signed(best_key));

    assign last_pos = fill_reg - CW'(1);
    assign pop_last = pop_reg - CW'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_EM_OUT);
    assign m_tdata   = rd_a;
    assign m_tlast   = (emit_reg == last_pos);

    always_comb begin
        case (state_reg)
            ST_UP_RD: rd_addr_a = parent_idx;
            ST_DN_RD: rd_addr_a = left_idx[AW-1:0];
            ST_PO_RD: rd_addr_a = pop_last[AW-1:0];
            default:  rd_addr_a = emit_reg[AW-1:0];
        endcase
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        keep_next  = keep_reg;
        mv_next    = mv_reg;
        pos_next   = pos_reg;
        lim_next   = lim_reg;
        pop_next   = pop_reg;
        emit_next  = emit_reg;
        drain_next = drain_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = mv_reg;
        rd_en      = 1'b0;
        sift_done  = 1'b0;

        if (cfg_valid) begin
            keep_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_OFFER) begin
                        if (has_room) begin
                            mv_next    = in_entry;
                            pos_next   = fill_reg[AW-1:0];
                            fill_next  = fill_reg + CW'(1);
                            drain_next = 1'b0;
                            state_next = (fill_reg == '0) ? ST_FIN : ST_UP_RD;
                        end else if ((fill_reg != '0) &&
                                     ($signed(in_entry.key) < $signed(root_reg.key))) begin
                            mv_next    = in_entry;
                            pos_next   = '0;
                            lim_next   = fill_reg;
                            drain_next = 1'b0;
                            state_next = ST_DN_RD;
                        end
                    end else if (fill_reg != '0) begin
                        pop_next   = fill_reg;
                        drain_next = 1'b1;
                        state_next = ST_PO_RD;
                    end
                end
            end
            ST_UP_RD: begin
                rd_en      = 1'b1;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if ($signed(rd_a.key) >= $signed(mv_reg.key)) begin
                    wr_data   = mv_reg;
                    sift_done = 1'b1;
                end else begin
                    // parent drops into the hole, hole moves up
                    wr_data    = rd_a;
                    pos_next   = parent_idx;
                    state_next = (parent_idx == '0) ? ST_FIN : ST_UP_RD;
                end
            end
            ST_DN_RD: begin
                if (left_idx >= lim_x) begin
                    state_next = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                wr_en = 1'b1;
                if (r_gt) begin
                    wr_data    = rd_b;
                    pos_next   = right_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else if (l_gt) begin
                    wr_data    = rd_a;
                    pos_next   = left_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    wr_data   = mv_reg;
                    sift_done = 1'b1;
                end
            end
            ST_FIN: begin
                wr_en     = 1'b1;
                sift_done = 1'b1;
            end
            ST_PO_RD: begin
                rd_en      = 1'b1;
                state_next = ST_PO_WR;
            end
            ST_PO_WR: begin
                // popped max parks past the shrinking heap, so ram ends up ascending
                wr_en    = 1'b1;
                wr_addr  = pop_last[AW-1:0];
                wr_data  = root_reg;
                mv_next  = rd_a;
                pos_next = '0;
                lim_next = pop_last;
                if (pop_last == '0) begin
                    emit_next  = '0;
                    state_next = ST_EM_RD;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_EM_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (m_tready) begin
                    if (m_tlast) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        emit_next  = emit_reg + CW'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (sift_done) begin
            if (drain_reg) begin
                pop_next   = pop_reg - CW'(1);
                state_next = ST_PO_RD;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    // shadow of the root slot so the offer compare needs no ram read
    assign root_next = (wr_en && (wr_addr == '0)) ? wr_data : root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            keep_reg  <= KEEP_W'(1);
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            keep_reg  <= keep_next;
            drain_reg <= drain_next;
        end
        mv_reg   <= mv_next;
        pos_reg  <= pos_next;
        lim_reg  <= lim_next;
        pop_reg  <= pop_next;
        emit_reg <= emit_next;
        root_reg <= root_next;
    end

    tkn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEEP)
    ) u_heap_ram (
        .clk       (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (right_idx[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(MAX_KEEP))
        else $error("fill level above heap size");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (fill_reg == '0))
        else $error("heap not empty after final result beat");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_OUT) |-> (emit_reg < fill_reg))
        else $error("emit index past fill level");

    a_sift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DN_CMP) |-> (XW'(pos_reg) < lim_x))
        else $error("sift position outside heap");

endmodule

FILE: tb/sv/tb_top.sv
// testbench for the top-k nearest heap selection unit: stimulus, prediction and checks
`timescale 1ns / 100ps

module tb_top;
    import tkn_pkg::*;

    localparam int HEAP_DEPTH = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] distance;
        logic                    last;
    } hit_t;

    // mirrors the bounded max-heap and holds the sorted hits still to come out
    class nearest_tracker;
        logic signed [KEY_W-1:0] keys[HEAP_DEPTH];
        logic [ID_W-1:0]         ids[HEAP_DEPTH];
        int                      fill;
        logic [KEEP_W-1:0]       keep_reg;
        hit_t                    due_hits[$];
        int                      errors;

        function new();
            fill = 0;
            keep_reg = 1;
            errors = 0;
        endfunction

        function void set_keep(logic [KEEP_W-1:0] value);
            keep_reg = value;
        endfunction

        function int pending();
            return due_hits.size();
        endfunction

        function void swap_slots(int a, int b);
            logic signed [KEY_W-1:0] tk;
            logic [ID_W-1:0]         ti;
            tk = keys[a];
            ti = ids[a];
            keys[a] = keys[b];
            ids[a] = ids[b];
            keys[b] = tk;
            ids[b] = ti;
        endfunction

        // left child wins a tie, swap only on strictly greater
        function void sink_root(int lim);
            int j;
            int l;
            int r;
            int m;
            j = 0;
            while (1) begin
                l = 2 * j + 1;
                r = l + 1;
                m = j;
                if (l < lim && keys[l] > keys[m]) m = l;
                if (r < lim && keys[r] > keys[m]) m = r;
                if (m == j) break;
                swap_slots(m, j);
                j = m;
            end
        endfunction

        function void raise_slot(int start);
            int j;
            int p;
            j = start;
            while (j > 0) begin
                p = (j - 1) >> 1;
                if (keys[p] >= keys[j]) break;
                swap_slots(p, j);
                j = p;
            end
        endfunction

        function void take_item(cmd_t cmd, logic signed [KEY_W-1:0] distance,
                                logic [ID_W-1:0] id);
            int   k;
            int   total;
            hit_t popped[HEAP_DEPTH];
            k = (keep_reg == 0) ? 1 : ((keep_reg > HEAP_DEPTH) ? HEAP_DEPTH : keep_reg);
            if (cmd == CMD_OFFER) begin
                if (fill < k && fill < HEAP_DEPTH) begin
                    keys[fill] = distance;
                    ids[fill] = id;
                    fill++;
                    raise_slot(fill - 1);
                end else if (fill > 0 && distance < keys[0]) begin
                    keys[0] = distance;
                    ids[0] = id;
                    sink_root(fill);
                end
            end else begin
                total = fill;
                // largest pops first, so fill the sorted list from the top down
                for (int n = total; n > 0; n--) begin
                    popped[n-1].id = ids[0];
                    popped[n-1].distance = keys[0];
                    popped[n-1].last = (n == total);
                    keys[0] = keys[n-1];
                    ids[0] = ids[n-1];
                    sink_root(n - 1);
                end
                fill = 0;
                for (int i = 0; i < total; i++) due_hits.push_back(popped[i]);
            end
        endfunction

        function void match_result(logic [ID_W-1:0] id, logic signed [KEY_W-1:0] distance,
                                   logic last);
            hit_t want;
            if (due_hits.size() == 0) begin
                $display("%0t: unexpected result beat id %h distance %h last %b",
                         $time, id, distance, last);
                errors++;
                return;
            end
            want = due_hits.pop_front();
            if (id !== want.id) begin
                $display("%0t: out_id expected %h actual %h", $time, want.id, id);
                errors++;
            end
            if (distance !== want.distance) begin
                $display("%0t: out_distance expected %h actual %h", $time, want.distance,
                         distance);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [KEEP_W-1:0]   cfg_data = '0;

    int             src_idle_pct = 23;
    int             sink_idle_pct = 63;
    int             stall_cycles = 0;
    nearest_tracker tracker;

    top_k_nearest_heap_select_unit #(.MAX_KEEP(HEAP_DEPTH)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(m_tdata[63:0], m_tdata[95:64], m_tlast);
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("top_k_nearest_heap_select_unit verification failed");
            $finish;
        end
    end

    task automatic send_beat(input cmd_t cmd, input logic signed [KEY_W-1:0] distance,
                             input logic [ID_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {id, distance};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        tracker.take_item(cmd, distance, id);
    endtask

    task automatic offer(input logic signed [KEY_W-1:0] distance, input logic [ID_W-1:0] id);
        send_beat(CMD_OFFER, distance, id);
    endtask

    task automatic drain();
        send_beat(CMD_DRAIN, $urandom, {$urandom, $urandom});
    endtask

    // hold off the sender until every hit is out and the last offer has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_keep(value);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_distance();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $urandom_range(16) - 8;    // narrow range to force ties
        if (sel < 45) return 32'sh8000_0000;
        if (sel < 50) return 32'sh7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic run_burst(input int count, input int drain_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < drain_pct)
                drain();
            else
                offer(pick_distance(), {$urandom, $urandom});
        end
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // keep_count still at its reset value of one
        offer(100, 64'd1);
        offer(50, 64'd2);
        offer(50, 64'd3);
        offer(200, 64'd4);
        drain();
        drain();
        wait_idle();

        write_keep(4);
        offer(32'sh7FFF_FFFF, '1);
        offer(32'sh8000_0000, '0);
        offer(0, 64'h5555_5555_5555_5555);
        offer(0, 64'hAAAA_AAAA_AAAA_AAAA);
        offer(-5, 64'd10);      // replaces root, both children tie
        offer(0, 64'd11);       // equal to root while full
        drain();
        wait_idle();

        write_keep(8);
        offer(30, 64'd20);
        offer(-30, 64'd21);
        offer(30, 64'd22);
        offer(7, 64'd23);
        offer(32'sh8000_0000, 64'd24);
        offer(12, 64'd25);
        wait_idle();
        // shrink k below the current fill level
        write_keep(2);
        offer(-1, 64'd26);
        offer(99, 64'd27);
        drain();

        wait_idle();
        write_keep(6);
        run_burst(20, 10);
        wait_idle();
        write_keep(64);
        run_burst(70, 3);
        drain();

        src_idle_pct = 63;
        sink_idle_pct = 23;
        wait_idle();
        write_keep(127);
        run_burst(10, 0);
        wait_idle();
        write_keep(2);
        run_burst(10, 0);
        drain();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        wait_idle();
        write_keep(0);
        run_burst(15, 15);
        wait_idle();
        write_keep($urandom_range(127));
        run_burst(15, 12);
        drain();

        wait_idle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("top_k_nearest_heap_select_unit verification clean");
        else
            $display("top_k_nearest_heap_select_unit verification failed");
        $finish;
    end

endmodule

FILE: sim.f
src/tkn_pkg.sv
src/tkn_ram.sv
src/top_k_nearest_heap_select_unit.sv
tb/sv/tb_top.sv
